/* rtl/msc_pkg.sv */
// Package: sizes, parameter memory layout, exp table and shared types.
package msc_pkg;

  localparam int unsigned Features = 64;
  localparam int unsigned Hidden = 32;
  localparam int unsigned Classes = 8;
  localparam int unsigned PmemDepth = 4096;

  localparam int unsigned FW = $clog2(Features);
  localparam int unsigned HW = $clog2(Hidden);
  localparam int unsigned CW = $clog2(Classes);
  localparam int unsigned AW = $clog2(PmemDepth);

  localparam int unsigned BaseStd = Features;
  localparam int unsigned BaseB1 = 2 * Features;
  localparam int unsigned BaseW1 = BaseB1 + Hidden;
  localparam int unsigned BaseB2 = BaseW1 + Features * Hidden;
  localparam int unsigned BaseW2 = BaseB2 + Classes;

  localparam logic [23:0] QOne = 24'd4096;
  localparam logic [12:0] Log2eQ12 = 13'd5909;

  typedef enum logic [3:0] {
    ST_IDLE, ST_STD_RD, ST_STD_DIV, ST_L1_BIAS, ST_L1_MAC, ST_L1_DONE,
    ST_L2_BIAS, ST_L2_MAC, ST_L2_DONE, ST_MAX, ST_EXP, ST_DIV, ST_EMIT
  } state_e;

  // Control handed from the sequencer to the MAC cell row.
  typedef struct packed {
    logic load_bias;
    logic mac_en;
    logic shift;
    logic relu;
  } cell_ctl_t;

  function automatic logic [16:0] exp2_tab(input logic [3:0] t);
    logic [16:0] r;
    case (t)
      4'd0: r = 17'd65536;  4'd1: r = 17'd62757;  4'd2: r = 17'd60097;
      4'd3: r = 17'd57549;  4'd4: r = 17'd55109;  4'd5: r = 17'd52773;
      4'd6: r = 17'd50535;  4'd7: r = 17'd48393;  4'd8: r = 17'd46341;
      4'd9: r = 17'd44376;  4'd10: r = 17'd42495; 4'd11: r = 17'd40693;
      4'd12: r = 17'd38968; 4'd13: r = 17'd37316; 4'd14: r = 17'd35734;
      default: r = 17'd34219;
    endcase
    return r;
  endfunction

  // Saturating add of a floor-shifted product into a 32-bit accumulator.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [55:0] p);
    logic signed [57:0] s;
    s = 58'(a) + 58'(p >>> 12);
    if (s > 58'sd2147483647) return 32'sh7fffffff;
    if (s < -58'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

endpackage

/* rtl/msc_divider.sv */
// Restoring divider, one quotient bit per cycle, signed and unsigned.
module msc_divider import msc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               signed_i,
  input  logic signed [48:0] num_i,
  input  logic signed [48:0] den_i,
  output logic               done_o,
  output logic signed [48:0] quo_o
);

  logic [47:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [48:0] trial;
  logic [47:0] na, da;

  always_comb begin
    na = (signed_i && num_i[48]) ? 48'(-num_i) : num_i[47:0];
    da = (signed_i && den_i[48]) ? 48'(-den_i) : den_i[47:0];
    trial = {rem_q, quo_q[47]} - {1'b0, den_q};
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    if (start_i) begin
      rem_d = '0; quo_d = na; den_d = da; cnt_d = 6'd48; busy_d = 1'b1;
      neg_d = signed_i && (num_i[48] ^ den_i[48]);
    end else if (busy_q) begin
      // Shift in one dividend bit and try subtracting.
      if (!trial[48]) begin
        rem_d = trial[47:0]; quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = {rem_q[46:0], quo_q[47]}; quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

/* rtl/msc_cell.sv */
// One MAC cell: holds one accumulator, passes its result to the next cell.
module msc_cell import msc_pkg::*; (
  input  logic               clk_i,
  input  cell_ctl_t          ctl_i,
  input  logic               sel_i,
  input  logic signed [31:0] x_i,
  input  logic signed [23:0] w_i,
  input  logic signed [31:0] chain_i,
  output logic signed [31:0] acc_o
);

  logic signed [31:0] acc_q, acc_d;
  logic signed [55:0] prod;

  always_comb begin
    prod = 56'(x_i) * 56'(w_i);
    acc_d = acc_q;
    if (ctl_i.shift) begin
      acc_d = chain_i;
    end else if (sel_i && ctl_i.load_bias) begin
      acc_d = 32'(w_i);
    end else if (sel_i && ctl_i.mac_en) begin
      acc_d = sat_add(acc_q, prod);
    end else if (sel_i && ctl_i.relu) begin
      acc_d = acc_q[31] ? '0 : acc_q;
    end
  end

  always_ff @(posedge clk_i) acc_q <= acc_d;

  assign acc_o = acc_q;

endmodule

/* rtl/mlp_softmax_classifier.sv */
// Top level: parameter memory, feature buffer, sequencer, MAC cell row, softmax.
// Usage: drive mode_i/index_i/value_i/last_i with start_i while busy_o is low.
// Mode 0 writes a parameter word, mode 1 a feature sample; each is one transfer
// per cycle, busy_o stays low. A feature sample with last_i high starts an
// inference and raises busy_o; it falls as the last result is presented.
// Inference: 64 standardize steps (mean and std fetch, then a divide), 32 hidden
// units (bias, 64 MACs, ReLU) on one cell of the row, 8 logits (bias, 32 MACs),
// then a max pass and an exp pass over the logits and 8 probability divisions.
// Run time is set by the divider and the single parameter memory read port.
// Results: 8 transfers, one per cycle, marked by valid_o; final_res_o on the
// last. The receiver cannot stall. Reset clears control only; memories are
// undefined until written.
module mlp_softmax_classifier import msc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [11:0] index_i,
  input  logic signed [23:0] value_i,
  input  logic        last_i,
  output logic        valid_o,
  output logic [2:0]  class_index_o,
  output logic [16:0] probability_o,
  output logic [2:0]  best_class_o,
  output logic        final_res_o
);

  logic signed [23:0] pmem [PmemDepth];
  logic signed [23:0] fbuf [Features];
  logic signed [23:0] xs [Features];
  logic signed [31:0] hid [Hidden];
  logic [16:0] ev [Classes];

  state_e state_q, state_d;
  logic [AW-1:0] raddr;
  logic signed [23:0] rdata_q, fdata_q;
  logic signed [23:0] mean_q, xdata_q;
  logic [8:0] i_q, i_d;
  logic [8:0] j_q, j_d;
  logic [1:0] ph_q, ph_d;
  logic accept;
  logic signed [31:0] mx_q, mx_d;
  logic [19:0] sum_q, sum_d;
  logic [2:0] best_q, best_d;
  logic [16:0] bestp_q, bestp_d;
  logic [16:0] pr [Classes];
  logic div_start, div_signed, div_done;
  logic signed [48:0] div_num, div_den, div_quo;
  cell_ctl_t ctl;
  logic signed [31:0] chain [Classes+1];
  logic signed [31:0] xop;
  logic valid_q;
  logic [2:0] oidx_q;
  logic signed [31:0] logit;
  logic [31:0] adiff;
  logic [44:0] yprod;
  logic [32:0] yv;
  logic [16:0] eval;
  logic signed [48:0] pdiff;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);

  // Store parameter words and samples; read the memory one address per cycle.
  always_ff @(posedge clk_i) begin
    if (accept && !mode_i) pmem[index_i] <= value_i;
    if (accept && mode_i && index_i < 12'(Features)) fbuf[index_i[FW-1:0]] <= value_i;
    rdata_q <= pmem[raddr];
    fdata_q <= fbuf[i_q[FW-1:0]];
  end

  // Address generator per step.
  always_comb begin
    raddr = '0;
    case (state_q)
      ST_STD_RD: raddr = (ph_q == 2'd0) ? AW'(i_q) : AW'(BaseStd + i_q);
      ST_L1_BIAS: raddr = AW'(BaseB1 + j_q);
      ST_L1_MAC: raddr = AW'(BaseW1 + i_q * Hidden + j_q);
      ST_L2_BIAS: raddr = AW'(BaseB2 + j_q);
      ST_L2_MAC: raddr = AW'(BaseW2 + i_q * Classes + j_q);
      default: raddr = '0;
    endcase
  end

  // Row of cells: cell k owns logit k; hidden units reuse cell 0 and are copied to hid.
  // Cell 0 feeds the far end, so a shift rotates the logits around the row.
  assign chain[Classes] = chain[0];
  for (genvar k = 0; k < Classes; k++) begin : g_cell
    msc_cell u_cell (
      .clk_i, .ctl_i(ctl),
      .sel_i((state_q == ST_L2_BIAS || state_q == ST_L2_MAC || state_q == ST_L2_DONE)
             ? (j_q[CW-1:0] == CW'(k)) : (k == 0)),
      .x_i(xop), .w_i(rdata_q), .chain_i(chain[k+1]), .acc_o(chain[k])
    );
  end

  msc_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .signed_i(div_signed),
    .num_i(div_num), .den_i(div_den), .done_o(div_done), .quo_o(div_quo)
  );

  assign pdiff = 49'(fdata_q) - 49'(mean_q);
  assign logit = chain[0];
  assign adiff = 32'(mx_q - logit);
  assign yprod = 45'(adiff) * 45'(Log2eQ12);
  assign yv = yprod[44:12];
  assign eval = (yv[32:12] >= 21'd17) ? 17'd0 : exp2_tab(yv[11:8]) >> yv[16:12];

  always_comb begin
    state_d = state_q; i_d = i_q; j_d = j_q; ph_d = ph_q;
    mx_d = mx_q; sum_d = sum_q; best_d = best_q; bestp_d = bestp_q;
    ctl = '0; div_start = 1'b0; div_signed = 1'b1; div_num = '0; div_den = '0;
    xop = '0;
    case (state_q)
      ST_IDLE: if (accept && mode_i && last_i) begin
        state_d = ST_STD_RD; i_d = '0; ph_d = '0;
      end
      // Fetch mean, then std, then divide.
      ST_STD_RD: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          ph_d = '0; state_d = ST_STD_DIV; div_start = 1'b1;
          div_num = pdiff <<< 12;
          div_den = (rdata_q == '0) ? 49'(QOne) : 49'(rdata_q);
        end
      end
      ST_STD_DIV: if (div_done) begin
        i_d = i_q + 9'd1; state_d = ST_STD_RD;
        if (i_q == 9'(Features - 1)) begin
          state_d = ST_L1_BIAS; i_d = '0; j_d = '0; ph_d = '0;
        end
      end
      ST_L1_BIAS, ST_L2_BIAS: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd1) begin
          ctl.load_bias = 1'b1; ph_d = '0; i_d = '0;
          state_d = (state_q == ST_L1_BIAS) ? ST_L1_MAC : ST_L2_MAC;
        end
      end
      // Pipelined: address i issues, and its data arrives in the cycle after.
      ST_L1_MAC, ST_L2_MAC: begin
        if (ph_q != 2'd0) begin
          ctl.mac_en = 1'b1;
          xop = (state_q == ST_L1_MAC) ? 32'(xdata_q) : hid[HW'(i_q - 9'd1)];
        end
        ph_d = 2'd1; i_d = i_q + 9'd1;
        if (i_q == ((state_q == ST_L1_MAC) ? 9'(Features) : 9'(Hidden))) begin
          ctl.mac_en = 1'b1; ph_d = '0;
          state_d = (state_q == ST_L1_MAC) ? ST_L1_DONE : ST_L2_DONE;
        end
      end
      ST_L1_DONE: begin
        ctl.relu = 1'b1; j_d = j_q + 9'd1; state_d = ST_L1_BIAS;
        if (j_q == 9'(Hidden - 1)) begin
          state_d = ST_L2_BIAS; j_d = '0;
        end
      end
      ST_L2_DONE: begin
        j_d = j_q + 9'd1; state_d = ST_L2_BIAS;
        if (j_q == 9'(Classes - 1)) begin
          state_d = ST_MAX; j_d = '0; mx_d = 32'sh80000000;
        end
      end
      // Rotate logits through the row to find the max, then the exps.
      ST_MAX: begin
        ctl.shift = 1'b1; j_d = j_q + 9'd1;
        if (logit > mx_q) mx_d = logit;
        if (j_q == 9'(Classes - 1)) begin
          state_d = ST_EXP; j_d = '0; sum_d = '0;
        end
      end
      ST_EXP: begin
        ctl.shift = 1'b1; j_d = j_q + 9'd1; sum_d = sum_q + 20'(eval);
        if (j_q == 9'(Classes - 1)) begin
          state_d = ST_DIV; j_d = '0; ph_d = '0; bestp_d = '0; best_d = '0;
        end
      end
      ST_DIV: begin
        div_signed = 1'b0;
        div_num = 49'({ev[CW'(j_q)], 16'd0}) + 49'(sum_q >> 1);
        div_den = 49'(sum_q);
        if (ph_q == 2'd0) begin
          div_start = 1'b1; ph_d = 2'd1;
        end else if (div_done) begin
          ph_d = '0; j_d = j_q + 9'd1;
          if (div_quo[16:0] > bestp_q) begin
            bestp_d = div_quo[16:0]; best_d = j_q[2:0];
          end
          if (j_q == 9'(Classes - 1)) begin
            state_d = ST_EMIT; j_d = '0;
          end
        end
      end
      ST_EMIT: begin
        j_d = j_q + 9'd1;
        if (j_q == 9'(Classes - 1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; i_q <= '0; j_q <= '0; ph_q <= '0; valid_q <= 1'b0;
    end else begin
      state_q <= state_d; i_q <= i_d; j_q <= j_d; ph_q <= ph_d;
      valid_q <= (state_q == ST_EMIT);
    end
  end

  // Datapath storage.
  always_ff @(posedge clk_i) begin
    mx_q <= mx_d; sum_q <= sum_d; best_q <= best_d; bestp_q <= bestp_d;
    oidx_q <= j_q[2:0];
    // Hold the mean while the std word is fetched.
    if (state_q == ST_STD_RD && ph_q == 2'd1) mean_q <= rdata_q;
    xdata_q <= xs[i_q[FW-1:0]];
    if (state_q == ST_STD_DIV && div_done) begin
      xs[i_q[FW-1:0]] <= (div_quo > 49'sd8388607) ? 24'sh7fffff :
                         (div_quo < -49'sd8388608) ? 24'sh800000 : div_quo[23:0];
    end
    if (state_q == ST_L1_DONE) hid[j_q[HW-1:0]] <= chain[0][31] ? '0 : chain[0];
    if (state_q == ST_EXP) ev[j_q[CW-1:0]] <= eval;
    if (state_q == ST_DIV && ph_q != 2'd0 && div_done) pr[j_q[CW-1:0]] <= div_quo[16:0];
  end

  assign valid_o = valid_q;
  assign class_index_o = oidx_q;
  assign probability_o = pr[oidx_q];
  assign best_class_o = best_q;
  assign final_res_o = valid_q && (oidx_q == 3'(Classes - 1));

endmodule

/* rtl/msc_checker.sv */
// Port checker for the classifier, bound to the top level.
module msc_checker import msc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic mode_i,
  input logic last_i,
  input logic valid_o,
  input logic [2:0] class_index_o,
  input logic final_res_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && mode_i && last_i |=> busy_o) else $error("no busy");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !mode_i |=> !busy_o) else $error("load busy");
  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && final_res_o |-> class_index_o == 3'(Classes - 1)) else $error("final");
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !final_res_o |=> valid_o && class_index_o == $past(class_index_o) + 3'd1)
    else $error("sequence");
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !final_res_o |-> busy_o) else $error("valid idle");

endmodule

bind mlp_softmax_classifier msc_checker u_msc_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .last_i, .valid_o,
  .class_index_o, .final_res_o
);
